// ===== hdl/priority_ready_queue_scheduler_defines.svh =====
// Assertion macros shared by the priority ready queue scheduler modules.
`ifndef PRIORITY_READY_QUEUE_SCHEDULER_DEFINES_SVH
`define PRIORITY_READY_QUEUE_SCHEDULER_DEFINES_SVH

// Checks a condition at every clock edge outside reset.
`define PRQ_ASSERT_ALWAYS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error(msg);

// Checks that a condition in one cycle implies another in the next cycle.
`define PRQ_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/prq_pkg.sv =====
// Shared types and constants of the priority ready queue scheduler.
package prq_pkg;

	localparam int QUEUE_DEPTH = 8;
	localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

	typedef logic [CNT_W-1:0] cnt_t;

	localparam logic FUNC_TICK   = 1'b0;
	localparam logic FUNC_ARRIVE = 1'b1;

	typedef struct packed {
		logic [7:0]  pri;
		logic [15:0] rem;
		logic [7:0]  id;
	} entry_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CMP,
		ST_UPD,
		ST_RES
	} state_t;

	typedef struct packed {
		logic capture;
		logic compare;
		logic update;
	} ctrl_cmd_t;

endpackage

// ===== hdl/prq_ctrl.sv =====
// Controller state machine that sequences one request through the datapath.
`include "priority_ready_queue_scheduler_defines.svh"

module prq_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	output logic               done,
	output prq_pkg::ctrl_cmd_t cmd
);
	import prq_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		cmd         = '0;
		done        = 1'b0;
		busy        = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				busy        = 1'b0;
				cmd.capture = start;
				if (start) begin
					state_d = ST_CMP;
				end
			end
			ST_CMP: begin
				cmd.compare = 1'b1;
				state_d     = ST_UPD;
			end
			ST_UPD: begin
				cmd.update = 1'b1;
				state_d    = ST_RES;
			end
			ST_RES: begin
				done    = 1'b1;
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	`PRQ_ASSERT_NEXT(a_accept_goes_busy, start && !busy, busy, "accepted request did not start")
	`PRQ_ASSERT_NEXT(a_done_then_idle, done, !busy && !done, "strobe not followed by idle")
	`PRQ_ASSERT_NEXT(a_update_then_done, cmd.update, done, "update not followed by result")

endmodule

// ===== hdl/prq_dp.sv =====
// Datapath holding the sorted ready queue, the compare stage and the result registers.
`include "priority_ready_queue_scheduler_defines.svh"

module prq_dp (
	input  logic               clk,
	input  logic               arst_n,
	input  prq_pkg::ctrl_cmd_t cmd,
	input  logic               func,
	input  logic [7:0]         task_id,
	input  logic [15:0]        burst_time,
	input  logic [7:0]         task_priority,
	output logic               finished,
	output logic [7:0]         finished_id,
	output logic               dropped,
	output logic               running_valid,
	output logic [7:0]         running_id,
	output logic [7:0]         running_priority,
	output logic [15:0]        running_remaining,
	output logic [3:0]         queued_count
);
	import prq_pkg::*;

	// Captured request.
	logic   func_q;
	entry_t new_q;

	// Queue storage, kept sorted by descending priority with the head at index 0.
	entry_t entries_q [QUEUE_DEPTH];
	cnt_t   count_q;

	// Compare stage results.
	logic [QUEUE_DEPTH-1:0] ge_s1;
	logic                   full_s1;
	logic                   empty_s1;
	logic                   last_s1;

	// Result registers.
	logic       finished_q;
	logic [7:0] finished_id_q;
	logic       dropped_q;

	// Insertion view: what each slot would take from its left neighbor.
	entry_t                 prev_entry [QUEUE_DEPTH];
	logic [QUEUE_DEPTH-1:0] ge_prev;

	always_comb begin
		prev_entry[0] = new_q;
		ge_prev[0]    = 1'b1;
		for (int k = 1; k < QUEUE_DEPTH; k++) begin
			prev_entry[k] = entries_q[k-1];
			ge_prev[k]    = ge_s1[k-1];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			func_q     <= func;
			new_q.id   <= task_id;
			new_q.rem  <= burst_time;
			new_q.pri  <= task_priority;
		end
		if (cmd.compare) begin
			// The valid entries are sorted, so ge_s1 is a run of ones from the head.
			for (int k = 0; k < QUEUE_DEPTH; k++) begin
				ge_s1[k] <= (cnt_t'(k) < count_q) && (entries_q[k].pri >= new_q.pri);
			end
			full_s1  <= (count_q == cnt_t'(QUEUE_DEPTH));
			empty_s1 <= (count_q == '0);
			last_s1  <= (entries_q[0].rem <= 16'd1);
		end
		if (cmd.update) begin
			if (func_q == FUNC_ARRIVE) begin
				if (!full_s1) begin
					for (int k = 0; k < QUEUE_DEPTH; k++) begin
						if (!ge_s1[k]) begin
							entries_q[k] <= ge_prev[k] ? new_q : prev_entry[k];
						end
					end
				end
			end else if (!empty_s1) begin
				if (last_s1) begin
					for (int k = 0; k < QUEUE_DEPTH - 1; k++) begin
						entries_q[k] <= entries_q[k+1];
					end
				end else begin
					entries_q[0].rem <= entries_q[0].rem - 16'd1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q       <= '0;
			finished_q    <= 1'b0;
			finished_id_q <= '0;
			dropped_q     <= 1'b0;
		end else if (cmd.update) begin
			finished_q    <= 1'b0;
			finished_id_q <= '0;
			dropped_q     <= 1'b0;
			if (func_q == FUNC_ARRIVE) begin
				if (full_s1) begin
					dropped_q <= 1'b1;
				end else begin
					count_q <= count_q + cnt_t'(1);
				end
			end else if (!empty_s1 && last_s1) begin
				finished_q    <= 1'b1;
				finished_id_q <= entries_q[0].id;
				count_q       <= count_q - cnt_t'(1);
			end
		end
	end

	assign finished          = finished_q;
	assign finished_id       = finished_id_q;
	assign dropped           = dropped_q;
	assign running_valid     = (count_q != '0);
	assign running_id        = running_valid ? entries_q[0].id  : 8'd0;
	assign running_priority  = running_valid ? entries_q[0].pri : 8'd0;
	assign running_remaining = running_valid ? entries_q[0].rem : 16'd0;
	assign queued_count      = 4'(count_q);

	`PRQ_ASSERT_ALWAYS(a_count_in_range, count_q <= cnt_t'(QUEUE_DEPTH), "queue count overflow")
	`PRQ_ASSERT_ALWAYS(a_finish_xor_drop, !(finished_q && dropped_q), "finish and drop together")
	`PRQ_ASSERT_NEXT(a_insert_counts, cmd.update && func_q == FUNC_ARRIVE && !full_s1, count_q == $past(count_q) + cnt_t'(1), "insert did not grow queue")

endmodule

// ===== hdl/priority_ready_queue_scheduler.sv =====
// Top level of the preemptive priority scheduler ready queue.
//
//  Channel   Handshake        Ports
//  --------  ---------------  ------------------------------------------------
//  request   start, busy      func, task_id, burst_time, task_priority
//  result    done (strobe)    finished, finished_id, dropped, running_valid,
//                             running_id, running_priority, running_remaining,
//                             queued_count
//
// A request is taken at a rising edge where start is high and busy is low.
// Each request passes through these steps from acceptance to the next possible
// acceptance: capture, a parallel priority compare against every slot, the
// shift-and-insert or pop/decrement update, and a one-cycle done strobe.
// The compare and update run in fixed stages of the datapath, so the sequence
// does not depend on queue fill. Reset clears the state machine, queue count
// and result registers; stored entries are never read before they are written.
// The receiver cannot stall: results hold only until the next request's update.
module priority_ready_queue_scheduler (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        func,
	input  logic [7:0]  task_id,
	input  logic [15:0] burst_time,
	input  logic [7:0]  task_priority,
	output logic        done,
	output logic        finished,
	output logic [7:0]  finished_id,
	output logic        dropped,
	output logic        running_valid,
	output logic [7:0]  running_id,
	output logic [7:0]  running_priority,
	output logic [15:0] running_remaining,
	output logic [3:0]  queued_count
);
	import prq_pkg::*;

	// Command word from the controller to the datapath for each request phase.
	ctrl_cmd_t cmd;

	// The controller only sequences; all queue state lives in the datapath.
	prq_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.cmd    (cmd)
	);

	// The datapath keeps the queue sorted with the running task at the head and
	// holds the result fields stable from the strobe until the next update.
	prq_dp u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (cmd),
		.func              (func),
		.task_id           (task_id),
		.burst_time        (burst_time),
		.task_priority     (task_priority),
		.finished          (finished),
		.finished_id       (finished_id),
		.dropped           (dropped),
		.running_valid     (running_valid),
		.running_id        (running_id),
		.running_priority  (running_priority),
		.running_remaining (running_remaining),
		.queued_count      (queued_count)
	);

endmodule
